FILE: rtl/bcts_pkg.sv
package bcts_pkg;

  // Hard cap on tiles per request; the final one emitted carries the last flag.
  localparam int unsigned MaxResults = 40;
  // Tile counter width, holds 0 .. MaxResults.
  localparam int unsigned CntW = 6;
  // Working width of the clip and tile arithmetic (signed sizes reach -2048).
  localparam int unsigned CalcW = 12;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StEmit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new request and clip its left and top edges
    logic advance;  // the current tile was taken, step to the next one
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // clipped request leaves nothing on screen
    logic last;     // current tile is the final one of the request
  } dp_status_t;

endpackage

FILE: rtl/bcts_ctrl.sv
module bcts_ctrl import bcts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSetup;
        end
      end
      StSetup: begin
        // A request that leaves nothing on screen produces no tiles.
        state_d = status_i.empty ? StIdle : StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          if (status_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/bcts_dpath.sv
module bcts_dpath import bcts_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240,
  parameter int unsigned TILE_WIDTH    = 64,
  parameter int unsigned TILE_HEIGHT   = 32
) (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic        [9:0]  source_x_i,
  input  logic        [9:0]  source_y_i,
  input  logic signed [10:0] region_width_i,
  input  logic signed [10:0] region_height_i,
  input  logic signed [10:0] target_x_i,
  input  logic signed [10:0] target_y_i,
  output logic        [10:0] tile_source_x_o,
  output logic        [10:0] tile_source_y_o,
  output logic        [9:0]  tile_screen_x_o,
  output logic        [9:0]  tile_screen_y_o,
  output logic        [6:0]  tile_width_o,
  output logic        [5:0]  tile_height_o,
  output logic               last_tile_o
);

  localparam logic [CalcW-1:0] ScrW  = CalcW'(SCREEN_WIDTH);
  localparam logic [CalcW-1:0] ScrH  = CalcW'(SCREEN_HEIGHT);
  localparam logic [CalcW-1:0] TileW = CalcW'(TILE_WIDTH);
  localparam logic [CalcW-1:0] TileH = CalcW'(TILE_HEIGHT);

  // Left and top clipping of the incoming request.
  logic signed [CalcW-1:0] w_ext, h_ext, tx_ext, ty_ext;
  logic signed [CalcW-1:0] w_clip, h_clip;
  logic        [CalcW-1:0] sx_clip, sy_clip;
  logic        [9:0]       tx_clip, ty_clip;

  assign w_ext  = CalcW'(region_width_i);
  assign h_ext  = CalcW'(region_height_i);
  assign tx_ext = CalcW'(target_x_i);
  assign ty_ext = CalcW'(target_y_i);

  assign w_clip  = tx_ext[CalcW-1] ? w_ext + tx_ext : w_ext;
  assign h_clip  = ty_ext[CalcW-1] ? h_ext + ty_ext : h_ext;
  assign sx_clip = tx_ext[CalcW-1] ? CalcW'(source_x_i) - tx_ext : CalcW'(source_x_i);
  assign sy_clip = ty_ext[CalcW-1] ? CalcW'(source_y_i) - ty_ext : CalcW'(source_y_i);
  assign tx_clip = tx_ext[CalcW-1] ? '0 : tx_ext[9:0];
  assign ty_clip = ty_ext[CalcW-1] ? '0 : ty_ext[9:0];

  logic        [10:0]      sx_q, sy_q;
  logic signed [CalcW-1:0] w_q, h_q;
  logic        [9:0]       tx_q, ty_q;
  logic        [9:0]       cx_q, cy_q;
  logic        [CntW-1:0]  n_q;

  // Current tile. Sizes are positive once the request reaches the tiling state.
  logic [CalcW-1:0] w_u, h_u;
  logic [CalcW-1:0] scr_x, scr_y, rem_w, rem_h;
  logic [CalcW-1:0] tw_raw, th_raw, tw, th;
  logic [CalcW-1:0] nxt_cx, nxt_cy;
  logic             col_more, row_more;

  assign w_u = w_q;
  assign h_u = h_q;

  assign scr_x  = CalcW'(tx_q) + CalcW'(cx_q);
  assign scr_y  = CalcW'(ty_q) + CalcW'(cy_q);
  assign rem_w  = w_u - CalcW'(cx_q);
  assign rem_h  = h_u - CalcW'(cy_q);
  assign tw_raw = (rem_w > TileW) ? TileW : rem_w;
  assign th_raw = (rem_h > TileH) ? TileH : rem_h;
  assign tw     = (scr_x + tw_raw >= ScrW) ? ScrW - scr_x : tw_raw;
  assign th     = (scr_y + th_raw >= ScrH) ? ScrH - scr_y : th_raw;

  assign nxt_cx   = CalcW'(cx_q) + TileW;
  assign nxt_cy   = CalcW'(cy_q) + TileH;
  assign col_more = (nxt_cx < w_u) && (scr_x + TileW < ScrW);
  assign row_more = (nxt_cy < h_u) && (scr_y + TileH < ScrH);

  assign status_o.empty = w_q[CalcW-1] || (w_q == '0) || h_q[CalcW-1] || (h_q == '0) ||
                          (CalcW'(tx_q) >= ScrW) || (CalcW'(ty_q) >= ScrH);
  // Every column that starts on screen yields at least one tile, so the tile
  // is final when neither another row nor another column follows, or at the MaxResults cap.
  assign status_o.last  = (n_q == CntW'(MaxResults - 1)) || (!row_more && !col_more);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= sx_clip[10:0];
      sy_q <= sy_clip[10:0];
      w_q  <= w_clip;
      h_q  <= h_clip;
      tx_q <= tx_clip;
      ty_q <= ty_clip;
      cx_q <= '0;
      cy_q <= '0;
      n_q  <= '0;
    end else if (cmd_i.advance) begin
      n_q <= n_q + CntW'(1);
      if (row_more) begin
        cy_q <= nxt_cy[9:0];
      end else begin
        cy_q <= '0;
        cx_q <= nxt_cx[9:0];
      end
    end
  end

  assign tile_source_x_o = sx_q + 11'(cx_q);
  assign tile_source_y_o = sy_q + 11'(cy_q);
  assign tile_screen_x_o = scr_x[9:0];
  assign tile_screen_y_o = scr_y[9:0];
  assign tile_width_o    = tw[6:0];
  assign tile_height_o   = th[5:0];
  assign last_tile_o     = status_o.last;

endmodule

FILE: rtl/blit_clip_tile_splitter_core.sv
// Channel  Handshake                Payload
// -------  -----------------------  ---------------------------------------------------------
// in       in_valid_i/in_stall_o    source_x/y, region_width/height, target_x/y
// out      out_valid_o/out_stall_i  tile_source_x/y, tile_screen_x/y, tile_width/height, last_tile
//
// A request passes through the accept cycle, a setup cycle that decides whether
// anything survives the clip, then one tile per cycle while out_stall_i is low,
// from the column and row counters. An empty request emits no tiles after setup.
// rst_ni clears only the controller state; the datapath reloads on every request.
// A stalled tile holds its payload; the next request is accepted only after the
// last tile of the current one has been taken.
module blit_clip_tile_splitter_core import bcts_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240,
  parameter int unsigned TILE_WIDTH    = 64,
  parameter int unsigned TILE_HEIGHT   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [9:0]  source_x_i,
  input  logic        [9:0]  source_y_i,
  input  logic signed [10:0] region_width_i,
  input  logic signed [10:0] region_height_i,
  input  logic signed [10:0] target_x_i,
  input  logic signed [10:0] target_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [10:0] tile_source_x_o,
  output logic        [10:0] tile_source_y_o,
  output logic        [9:0]  tile_screen_x_o,
  output logic        [9:0]  tile_screen_y_o,
  output logic        [6:0]  tile_width_o,
  output logic        [5:0]  tile_height_o,
  output logic               last_tile_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller sequences accept, setup and tile emission.
  bcts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // The datapath clips the request and walks the tile grid column by column.
  bcts_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TILE_WIDTH    (TILE_WIDTH),
    .TILE_HEIGHT   (TILE_HEIGHT)
  ) u_dpath (
    .clk_i           (clk_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .source_x_i      (source_x_i),
    .source_y_i      (source_y_i),
    .region_width_i  (region_width_i),
    .region_height_i (region_height_i),
    .target_x_i      (target_x_i),
    .target_y_i      (target_y_i),
    .tile_source_x_o (tile_source_x_o),
    .tile_source_y_o (tile_source_y_o),
    .tile_screen_x_o (tile_screen_x_o),
    .tile_screen_y_o (tile_screen_y_o),
    .tile_width_o    (tile_width_o),
    .tile_height_o   (tile_height_o),
    .last_tile_o     (last_tile_o)
  );

`ifndef SYNTHESIS
  // A new request is never taken while a tile is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o && out_valid_o))
    else $error("request accepted while a tile is pending");

  // The setup cycle follows every accepted request.
  a_setup_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("tile offered in the setup cycle");

  // Taking the last tile ends the request.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_tile_o) |=> !out_valid_o)
    else $error("tile offered after the last tile");

  // Every emitted tile is non-empty, within tile size and starts on screen.
  a_tile_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tile_width_o != '0) && (tile_width_o <= 7'(TILE_WIDTH)) &&
                    (tile_height_o != '0) && (tile_height_o <= 6'(TILE_HEIGHT)) &&
                    (tile_screen_x_o < 10'(SCREEN_WIDTH)) &&
                    (tile_screen_y_o < 10'(SCREEN_HEIGHT)))
    else $error("tile outside its size or screen bounds");
`endif

endmodule
